// ===== rtl/sfd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_pkg: shared types for the signed floor divider
// Control and status records that pass between the top level and the
// serial divider core.
// ----------------------------------------------------------------------------
package sfd_pkg;

    // Control from the sequencer to the serial core.
    typedef struct packed {
        logic load;     // start a new magnitude division
    } sfd_core_ctl_t;

    // Status from the serial core back to the sequencer.
    typedef struct packed {
        logic active;   // iterations in progress
        logic done;     // one-cycle pulse: quotient and remainder are final
    } sfd_core_sts_t;

endpackage

// ===== rtl/sfd_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_core: bit-serial restoring divider on magnitudes
// One quotient bit per cycle. The dividend shifts out of the top of the
// quotient register while quotient bits shift in at the bottom.
// ----------------------------------------------------------------------------
module sfd_core
    import sfd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  sfd_core_ctl_t         ctl,
    input  logic [DATA_WIDTH-1:0] mag_a,
    input  logic [DATA_WIDTH-1:0] mag_b,
    output sfd_core_sts_t         sts,
    output logic [DATA_WIDTH-1:0] quo,
    output logic [DATA_WIDTH-1:0] rem
);

    localparam int CNT_W = $clog2(DATA_WIDTH + 1);

    logic [DATA_WIDTH-1:0] rem_reg, rem_next;
    logic [DATA_WIDTH-1:0] quo_reg, quo_next;
    logic [DATA_WIDTH-1:0] div_reg, div_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  active_reg, active_next;
    logic                  done_reg, done_next;

    logic [DATA_WIDTH:0]   trial;

    // Shift the next dividend bit into the partial remainder and try the
    // subtraction; the extra top bit catches the borrow.
    assign trial = {rem_reg, quo_reg[DATA_WIDTH-1]} - {1'b0, div_reg};

    always_comb
    begin
        rem_next    = rem_reg;
        quo_next    = quo_reg;
        div_next    = div_reg;
        cnt_next    = cnt_reg;
        active_next = active_reg;
        done_next   = 1'b0;
        if (ctl.load)
        begin
            rem_next    = '0;
            quo_next    = mag_a;
            div_next    = mag_b;
            cnt_next    = CNT_W'(DATA_WIDTH);
            active_next = 1'b1;
        end
        else if (active_reg)
        begin
            if (trial[DATA_WIDTH])
            begin
                rem_next = {rem_reg[DATA_WIDTH-2:0], quo_reg[DATA_WIDTH-1]};
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b0};
            end
            else
            begin
                rem_next = trial[DATA_WIDTH-1:0];
                quo_next = {quo_reg[DATA_WIDTH-2:0], 1'b1};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                active_next = 1'b0;
                done_next   = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            cnt_reg    <= cnt_next;
            active_reg <= active_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign sts.active = active_reg;
    assign sts.done   = done_reg;
    assign quo        = quo_reg;
    assign rem        = rem_reg;

endmodule

// ===== rtl/signed_floor_divider.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_floor_divider: signed division rounded toward minus infinity
// A request is taken when start is high and busy is low. The result is
// shown for exactly one cycle with done high and must be captured then,
// since the receiver cannot hold it off. The bit-serial core produces one
// quotient bit per cycle. A zero divisor skips the core and raises done
// straight from the magnitude state. busy stays high from acceptance until
// the done cycle, so one request is in flight at a time.
// ----------------------------------------------------------------------------
//
// The quotient is the floor of dividend / divisor, and the remainder has the
// sign of the divisor with a magnitude below that of the divisor. A zero
// divisor raises div_by_zero with zero quotient and remainder. The most
// negative dividend divided by minus one raises overflow, and the quotient
// saturates to the largest positive value with a zero remainder.
//
// Flow: the operands are latched, turned into magnitudes, divided by the
// serial core; the fix state then applies the floor correction, and the
// sign state applies the sign of the remainder as it loads the result registers.
module signed_floor_divider
    import sfd_pkg::*;
#(
    parameter int DATA_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic signed [DATA_WIDTH-1:0] dividend,
    input  logic signed [DATA_WIDTH-1:0] divisor,
    output logic                         done,
    output logic signed [DATA_WIDTH-1:0] quotient,
    output logic signed [DATA_WIDTH-1:0] remainder,
    output logic                         div_by_zero,
    output logic                         overflow
);

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAG,
        ST_RUN,
        ST_FIX,
        ST_SIGN
    } state_t;

    state_t                state_reg;
    logic [DATA_WIDTH-1:0] a_reg;
    logic [DATA_WIDTH-1:0] b_reg;
    logic [DATA_WIDTH-1:0] ma_reg;
    logic [DATA_WIDTH-1:0] mb_reg;
    logic [DATA_WIDTH-1:0] qf_reg;
    logic [DATA_WIDTH-1:0] rf_reg;
    logic                  ovf_reg;
    logic                  load_reg;
    logic                  done_reg;
    logic [DATA_WIDTH-1:0] quo_out_reg;
    logic [DATA_WIDTH-1:0] rem_out_reg;
    logic                  dz_out_reg;
    logic                  ovf_out_reg;

    logic                  a_neg;
    logic                  b_neg;
    logic                  signs_differ;
    sfd_core_ctl_t         core_ctl;
    sfd_core_sts_t         core_sts;
    logic [DATA_WIDTH-1:0] core_quo;
    logic [DATA_WIDTH-1:0] core_rem;

    assign a_neg        = a_reg[DATA_WIDTH-1];
    assign b_neg        = b_reg[DATA_WIDTH-1];
    assign signs_differ = a_neg ^ b_neg;
    assign core_ctl.load = load_reg;

    sfd_core #(
        .DATA_WIDTH(DATA_WIDTH)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (core_ctl),
        .mag_a (ma_reg),
        .mag_b (mb_reg),
        .sts   (core_sts),
        .quo   (core_quo),
        .rem   (core_rem)
    );

    // Control state and the one-cycle strobes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            load_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            load_reg <= 1'b0;
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= ST_MAG;
                    end
                end
                ST_MAG:
                begin
                    if (b_reg == '0)
                    begin
                        // Zero divisor: report at once, nothing to divide.
                        done_reg  <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        load_reg  <= 1'b1;
                        state_reg <= ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (core_sts.done)
                    begin
                        state_reg <= ST_FIX;
                    end
                end
                ST_FIX:
                begin
                    state_reg <= ST_SIGN;
                end
                ST_SIGN:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers; their contents matter only under the control above.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    a_reg <= $unsigned(dividend);
                    b_reg <= $unsigned(divisor);
                end
            end
            ST_MAG:
            begin
                ma_reg <= a_neg ? (~a_reg + 1'b1) : a_reg;
                mb_reg <= b_neg ? (~b_reg + 1'b1) : b_reg;
                if (b_reg == '0)
                begin
                    quo_out_reg <= '0;
                    rem_out_reg <= '0;
                    dz_out_reg  <= 1'b1;
                    ovf_out_reg <= 1'b0;
                end
            end
            ST_FIX:
            begin
                // Floor correction when the signs differ: a nonzero remainder
                // takes the quotient from -q to -q-1, which is ~q, and the
                // remainder over to the other side of zero.
                ovf_reg <= 1'b0;
                rf_reg  <= core_rem;
                if (signs_differ)
                begin
                    if (core_rem != '0)
                    begin
                        qf_reg <= ~core_quo;
                        rf_reg <= mb_reg - core_rem;
                    end
                    else
                    begin
                        qf_reg <= ~core_quo + 1'b1;
                    end
                end
                else if (core_quo[DATA_WIDTH-1])
                begin
                    // Only the most negative value over minus one gets here.
                    qf_reg  <= MAX_POS;
                    ovf_reg <= 1'b1;
                end
                else
                begin
                    qf_reg <= core_quo;
                end
            end
            ST_SIGN:
            begin
                quo_out_reg <= qf_reg;
                rem_out_reg <= b_neg ? (~rf_reg + 1'b1) : rf_reg;
                dz_out_reg  <= 1'b0;
                ovf_out_reg <= ovf_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign quotient    = $signed(quo_out_reg);
    assign remainder   = $signed(rem_out_reg);
    assign div_by_zero = dz_out_reg;
    assign overflow    = ovf_out_reg;

endmodule

// ===== rtl/sfd_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfd_checker: port-level checks for the signed floor divider
// Watches the request and result ports and flags illegal result patterns.
// ----------------------------------------------------------------------------
module sfd_checker
#(
    parameter int DATA_WIDTH = 32
)
(
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic                         done,
    input logic signed [DATA_WIDTH-1:0] quotient,
    input logic signed [DATA_WIDTH-1:0] remainder,
    input logic                         div_by_zero,
    input logic                         overflow
);

    localparam logic [DATA_WIDTH-1:0] MAX_POS = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    // An accepted request keeps the block busy on the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted request did not raise busy");

    // The result strobe comes when the block has finished its request.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done raised while busy");

    // The strobe lasts one cycle per request.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // A zero divisor yields zero results and no overflow.
    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_by_zero |-> quotient == '0 && remainder == '0 && !overflow)
        else $error("division by zero with nonzero result");

    // Overflow saturates the quotient with a zero remainder.
    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow |-> $unsigned(quotient) == MAX_POS && remainder == '0
            && !div_by_zero)
        else $error("overflow result not saturated");

endmodule

bind signed_floor_divider sfd_checker #(.DATA_WIDTH(DATA_WIDTH)) u_sfd_checker (.*);
